// ===== rtl/core/rac_pkg.sv =====
// Shared types and constants for the range add / copy / sum array.
// Depends on nothing; rac_walk, the top level and the bench import it.
package rac_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W  = $clog2(DEPTH + 1);
	// bounds arithmetic: index fields are 11 bits and index + span reaches 12
	localparam int CALC_W = (LEN_W > 12) ? LEN_W : 12;

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_ADD  = 2'd1,
		FUNC_COPY = 2'd2,
		FUNC_SUM  = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [10:0]        first_index;
		logic [10:0]        second_index;
		logic [9:0]         span;
		logic signed [31:0] amount;
	} req_word_t;

	typedef struct packed {
		logic signed [63:0] range_total;
		logic               bad_range;
	} rsp_word_t;

	// one walk over the store, issued by the top level
	typedef struct packed {
		func_t              op;
		logic [ADDR_W-1:0]  rd_start;
		logic [ADDR_W-1:0]  wr_start;
		logic [ADDR_W-1:0]  last;
		logic               descend;
		logic signed [31:0] amount;
	} walk_cmd_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] total;
	} walk_stat_t;

endpackage

// ===== rtl/core/rac_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/rac_walk.sv =====
// Store walker: drives the value RAM for loads and range walks, one entry a cycle.
// Depends on rac_pkg.
module rac_walk
	import rac_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  walk_cmd_t         cmd,
	output walk_stat_t        stat,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic [31:0]       ram_wdata,
	output logic              ram_re,
	output logic [ADDR_W-1:0] ram_raddr,
	input  logic [31:0]       ram_rdata
);

	typedef enum logic {
		W_IDLE,
		W_RUN
	} wstate_t;

	wstate_t            wstate_q;
	func_t              op_q;
	logic [ADDR_W-1:0]  rd_addr_q;
	logic [ADDR_W-1:0]  wr_addr_q;
	logic [ADDR_W-1:0]  remain_q;
	logic               descend_q;
	logic signed [31:0] amount_q;
	logic signed [63:0] acc_q;
	logic               valid_s1;
	logic               last_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;

	logic               issue;
	logic signed [63:0] acc_next;
	logic               walk_we;
	logic [31:0]        walk_wdata;

	assign issue    = (wstate_q == W_RUN);
	assign acc_next = acc_q + 64'(signed'(ram_rdata));

	always_comb begin
		walk_we    = 1'b0;
		walk_wdata = ram_rdata;
		case (op_q)
			FUNC_ADD: begin
				walk_we    = valid_s1;
				walk_wdata = ram_rdata + amount_q;
			end
			FUNC_COPY: begin
				walk_we    = valid_s1;
				walk_wdata = ram_rdata;
			end
			default: begin
				walk_we    = 1'b0;
				walk_wdata = ram_rdata;
			end
		endcase
	end

	// a load writes in its accept cycle; walk writes use the registered read data, tracked by valid_s1 and wr_addr_s1
	always_comb begin
		if (walk_we) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = walk_wdata;
		end else begin
			ram_we    = start && (cmd.op == FUNC_LOAD);
			ram_waddr = cmd.wr_start;
			ram_wdata = cmd.amount;
		end
	end

	assign ram_re    = issue;
	assign ram_raddr = rd_addr_q;

	assign stat.done  = valid_s1 && last_s1;
	assign stat.total = acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wstate_q   <= W_IDLE;
			op_q       <= FUNC_LOAD;
			rd_addr_q  <= '0;
			wr_addr_q  <= '0;
			remain_q   <= '0;
			descend_q  <= 1'b0;
			amount_q   <= '0;
			acc_q      <= '0;
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
			wr_addr_s1 <= '0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				last_s1    <= (remain_q == '0);
				wr_addr_s1 <= wr_addr_q;
			end
			if (valid_s1) begin
				acc_q <= acc_next;
			end
			case (wstate_q)
				W_IDLE: begin
					if (start && (cmd.op != FUNC_LOAD)) begin
						wstate_q  <= W_RUN;
						op_q      <= cmd.op;
						rd_addr_q <= cmd.rd_start;
						wr_addr_q <= cmd.wr_start;
						remain_q  <= cmd.last;
						descend_q <= cmd.descend;
						amount_q  <= cmd.amount;
						acc_q     <= '0;
					end
				end
				W_RUN: begin
					// advance both pointers; stop issuing after the final entry
					if (descend_q) begin
						rd_addr_q <= rd_addr_q - 1'b1;
						wr_addr_q <= wr_addr_q - 1'b1;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
						wr_addr_q <= wr_addr_q + 1'b1;
					end
					if (remain_q == '0) begin
						wstate_q <= W_IDLE;
					end else begin
						remain_q <= remain_q - 1'b1;
					end
				end
				default: begin
					wstate_q <= W_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/range_add_copy_sum_array.sv =====
// Top level of the range add / copy / sum array: request checks, length, result word.
// Depends on rac_pkg, rac_walk and rac_ram.
//
// The block keeps up to DEPTH signed 32-bit values, positions numbered from 1, in one
// RAM with a single write port and a single registered read port. A request word is
// taken only while no earlier request is in progress. A load is written in its accept
// cycle and gives no response. A range add, range copy or range sum over n entries
// walks the RAM one entry per cycle through its read port and holds the request side
// until the walk is done; a sum then moves its total through res_q into the response
// register, which is separate from the request side and holds the word until it is
// taken. A response that finds the previous word still waiting in that register holds
// the request side until the previous word is taken. Add writes each entry back in the
// cycle after reading it. Copy walks downward when the destination lies above the
// source and upward otherwise, so every source entry is read before anything
// overwrites it (memmove behavior). A request whose positions fall outside the loaded
// length, or a load into a full store, changes nothing and returns one response with
// bad_range set and range_total zero.
// Only loaded entries are ever read, so the RAM needs no clearing after reset.
module range_add_copy_sum_array
	import rac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_BUSY,
		T_EMIT
	} tstate_t;

	tstate_t          tstate_q;
	logic [LEN_W-1:0] len_q;
	func_t            op_q;
	rsp_word_t        res_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q;

	logic              accept;
	func_t             func;
	logic [CALC_W-1:0] a_w;
	logic [CALC_W-1:0] b_w;
	logic [CALC_W-1:0] span_w;
	logic [CALC_W-1:0] len_w;
	logic              req_ok;
	logic              start;
	walk_cmd_t         cmd;
	walk_stat_t        stat;
	logic              rsp_free;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [31:0]       ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [31:0]       ram_rdata;

	assign req_ready = (tstate_q == T_IDLE);
	assign accept    = req_valid && req_ready;
	assign func      = func_t'(req.func);

	assign a_w    = CALC_W'(req.first_index);
	assign b_w    = CALC_W'(req.second_index);
	assign span_w = CALC_W'(req.span);
	assign len_w  = CALC_W'(len_q);

	// bounds checks, per function
	always_comb begin
		case (func)
			FUNC_LOAD: req_ok = (len_q != LEN_W'(DEPTH));
			FUNC_COPY: req_ok = (a_w != '0) && (b_w != '0) &&
				((a_w + span_w) <= len_w) && ((b_w + span_w) <= len_w);
			FUNC_ADD,
			FUNC_SUM:  req_ok = (a_w != '0) && (a_w <= b_w) && (b_w <= len_w);
			default:   req_ok = 1'b0;
		endcase
	end

	assign start = accept && req_ok;

	// walk command: copy runs downward when the destination lies above the source
	always_comb begin
		logic [CALC_W-1:0] a0;
		logic [CALC_W-1:0] b0;
		logic [CALC_W-1:0] rd_end;
		logic [CALC_W-1:0] wr_end;
		logic [CALC_W-1:0] run_len;
		a0      = a_w - 1'b1;
		b0      = b_w - 1'b1;
		rd_end  = a0 + span_w;
		wr_end  = b0 + span_w;
		run_len = b_w - a_w;
		cmd.op     = func;
		cmd.amount = req.amount;
		case (func)
			FUNC_LOAD: begin
				cmd.rd_start = len_q[ADDR_W-1:0];
				cmd.wr_start = len_q[ADDR_W-1:0];
				cmd.last     = '0;
				cmd.descend  = 1'b0;
			end
			FUNC_COPY: begin
				cmd.descend = (b_w > a_w);
				cmd.last    = span_w[ADDR_W-1:0];
				if (b_w > a_w) begin
					cmd.rd_start = rd_end[ADDR_W-1:0];
					cmd.wr_start = wr_end[ADDR_W-1:0];
				end else begin
					cmd.rd_start = a0[ADDR_W-1:0];
					cmd.wr_start = b0[ADDR_W-1:0];
				end
			end
			default: begin
				cmd.rd_start = a0[ADDR_W-1:0];
				cmd.wr_start = a0[ADDR_W-1:0];
				cmd.last     = run_len[ADDR_W-1:0];
				cmd.descend  = 1'b0;
			end
		endcase
	end

	rac_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.stat      (stat),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	rac_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tstate_q    <= T_IDLE;
			len_q       <= '0;
			op_q        <= FUNC_LOAD;
			res_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// drop the response word once taken, unless a new one loads behind it
			if (rsp_valid_q && rsp_ready && (tstate_q != T_EMIT)) begin
				rsp_valid_q <= 1'b0;
			end
			case (tstate_q)
				T_IDLE: begin
					if (accept) begin
						op_q <= func;
						if (!req_ok) begin
							res_q.range_total <= '0;
							res_q.bad_range   <= 1'b1;
							tstate_q          <= T_EMIT;
						end else if (func == FUNC_LOAD) begin
							len_q <= len_q + 1'b1;
						end else begin
							tstate_q <= T_BUSY;
						end
					end
				end
				T_BUSY: begin
					if (stat.done) begin
						if (op_q == FUNC_SUM) begin
							res_q.range_total <= stat.total;
							res_q.bad_range   <= 1'b0;
							tstate_q          <= T_EMIT;
						end else begin
							tstate_q <= T_IDLE;
						end
					end
				end
				T_EMIT: begin
					// hold the result until the response register frees up
					if (rsp_free) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						tstate_q    <= T_IDLE;
					end
				end
				default: begin
					tstate_q <= T_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for range_add_copy_sum_array: load, range add, range copy and range sum.
// Depends on rac_pkg and the block's RTL; a shadow copy of the array predicts every response.
module tb;
	import rac_pkg::*;

	// Longest quiet stretch we tolerate: a full-depth walk, the forced receiver
	// hold-off and the closing wait all fit many times over.
	localparam int STALL_LIMIT    = 20000;
	localparam int RX_HOLD_CYCLES = 3000;
	localparam int SETTLE_CYCLES  = 2 * DEPTH;

	typedef struct {
		req_word_t word;
		int        phase;
		bit        drain;
		bit        hold;
	} backlog_item_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	range_add_copy_sum_array dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Idle odds per traffic phase: sender light / receiver heavy, then swapped,
	// then both always willing.
	int tx_idle_pct [3] = '{14, 52, 0};
	int rx_idle_pct [3] = '{52, 14, 0};

	backlog_item_t      req_backlog [$];
	rsp_word_t          rsp_due [$];

	// Shadow of the array contents and its loaded length.
	logic signed [31:0] held_values [DEPTH];
	int                 held_len = 0;

	// Generator bookkeeping: loaded length as the stimulus will leave it.
	int                 fill_level = 0;
	int                 gen_phase = 0;
	bit                 gen_drain = 1'b0;
	bit                 gen_hold = 1'b0;

	int                 error_count = 0;
	int                 cycle_no = 0;
	int                 stall_cycles = 0;
	bit                 req_hs = 1'b0;
	bit                 rsp_hs = 1'b0;
	int                 cur_phase = 0;
	int                 hold_token = 0;
	int                 hold_seen = 0;
	int                 hold_left = 0;

	bit                 rsp_expected;
	rsp_word_t          rsp_want;
	rsp_word_t          rsp_got;
	logic               next_valid;
	req_word_t          next_word;
	backlog_item_t      head;

	task automatic flag_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycle_no, what);
		error_count++;
	endtask

	// Apply one accepted request word to the shadow array and tell whether it
	// produces a response, and which one.
	function automatic void range_request_effect(input req_word_t w, output bit gives,
			output rsp_word_t r);
		int                 a;
		int                 b;
		int                 s;
		int                 i;
		logic signed [63:0] acc;
		a = w.first_index;
		b = w.second_index;
		s = w.span;
		acc = '0;
		gives = 1'b1;
		r.range_total = '0;
		r.bad_range = 1'b1;
		case (func_t'(w.func))
			FUNC_LOAD: begin
				if (held_len < DEPTH) begin
					held_values[held_len] = w.amount;
					held_len++;
					gives = 1'b0;
				end
			end
			FUNC_COPY: begin
				if (a >= 1 && b >= 1 && a + s <= held_len && b + s <= held_len) begin
					gives = 1'b0;
					// walk away from the overlap so sources are read before overwrite
					if (b < a) begin
						for (i = 0; i <= s; i++)
							held_values[b - 1 + i] = held_values[a - 1 + i];
					end else begin
						for (i = s; i >= 0; i--)
							held_values[b - 1 + i] = held_values[a - 1 + i];
					end
				end
			end
			default: begin
				if (a >= 1 && a <= b && b <= held_len) begin
					if (func_t'(w.func) == FUNC_ADD) begin
						for (i = a - 1; i < b; i++)
							held_values[i] = held_values[i] + w.amount;
						gives = 1'b0;
					end else begin
						for (i = a - 1; i < b; i++)
							acc = acc + held_values[i];
						r.range_total = acc;
						r.bad_range = 1'b0;
					end
				end
			end
		endcase
	endfunction

	task automatic queue_req(input func_t f, input int a, input int b, input int s,
			input logic [31:0] amt);
		backlog_item_t it;
		it.word.func = f;
		it.word.first_index = a[10:0];
		it.word.second_index = b[10:0];
		it.word.span = s[9:0];
		it.word.amount = amt;
		it.phase = gen_phase;
		it.drain = gen_drain;
		it.hold = gen_hold;
		gen_drain = 1'b0;
		gen_hold = 1'b0;
		req_backlog.push_back(it);
		if (f == FUNC_LOAD && fill_level < DEPTH)
			fill_level++;
	endtask

	function automatic logic [31:0] pick_amount();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Mostly short ranges so walks stay cheap; now and then up to the whole length.
	function automatic int pick_count(input int limit);
		if ($urandom_range(15) == 0)
			return $urandom_range(limit, 1);
		return $urandom_range((limit < 8) ? limit : 8, 1);
	endfunction

	task automatic queue_random_req();
		int pick;
		int cnt;
		int a;
		int b;
		int lim;
		int off;
		pick = $urandom_range(99);
		if (fill_level < 2 || pick < 22) begin
			queue_req(FUNC_LOAD, $urandom_range(2047), $urandom_range(2047),
				$urandom_range(1023), pick_amount());
		end else if (pick < 88) begin
			cnt = pick_count(fill_level);
			lim = fill_level - cnt + 1;
			a = $urandom_range(lim, 1);
			if (pick < 42) begin
				queue_req(FUNC_ADD, a, a + cnt - 1, $urandom_range(1023), pick_amount());
			end else if (pick < 64) begin
				// half the copies land close to their source to exercise overlap
				off = $urandom_range(3);
				if ($urandom_range(1))
					b = $urandom_range(lim, 1);
				else if ($urandom_range(1))
					b = (a + off <= lim) ? a + off : lim;
				else
					b = (a > off) ? a - off : 1;
				queue_req(FUNC_COPY, a, b, cnt - 1, $urandom());
			end else begin
				queue_req(FUNC_SUM, a, a + cnt - 1, $urandom_range(1023), $urandom());
			end
		end else if (pick < 96) begin
			// broken requests: each misses the bounds by the smallest step
			case ($urandom_range(3))
				0: queue_req($urandom_range(1) ? FUNC_ADD : FUNC_SUM,
					$urandom_range(fill_level, 1), fill_level + 1,
					$urandom_range(1023), $urandom());
				1: begin
					a = $urandom_range(fill_level - 1, 1);
					queue_req($urandom_range(1) ? FUNC_ADD : FUNC_SUM, a + 1, a,
						$urandom_range(1023), $urandom());
				end
				2: queue_req(func_t'($urandom_range(3, 1)), 0,
					$urandom_range(fill_level, 1), 0, $urandom());
				default: begin
					a = $urandom_range(fill_level, 2);
					queue_req(FUNC_COPY, a, $urandom_range(fill_level, 1),
						fill_level + 1 - a, $urandom());
				end
			endcase
		end else begin
			queue_req(func_t'($urandom_range(3)), $urandom_range(2047),
				$urandom_range(2047), $urandom_range(1023), $urandom());
		end
	endtask

	// Driver: present the oldest pending word at the falling edge and hold it
	// until the block takes it.
	always @(negedge clk) begin
		if (arst_n) begin
			next_valid = req_valid;
			next_word = req;
			if (req_valid && req_hs) begin
				req_backlog.delete(0);
				next_valid = 1'b0;
			end
			if (!next_valid && req_backlog.size() != 0) begin
				head = req_backlog[0];
				// a drain-marked word waits until every response is home
				if (!(head.drain && rsp_due.size() != 0) &&
						$urandom_range(99) >= tx_idle_pct[head.phase]) begin
					next_valid = 1'b1;
					next_word = head.word;
					cur_phase <= head.phase;
					if (head.hold)
						hold_token <= hold_token + 1;
				end
			end
			req_valid <= next_valid;
			req <= next_word;
		end
	end

	// Receiver: random back-pressure, plus one long hold-off when the driver
	// hands over the marked word.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_token) begin
				hold_seen = hold_token;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rx_idle_pct[cur_phase]);
			end
		end
	end

	// Monitor: sample both channels at the rising edge, predict on accepted
	// requests, check accepted responses against the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_hs = 1'b0;
			rsp_hs = 1'b0;
			stall_cycles = 0;
		end else begin
			cycle_no++;
			req_hs = req_valid && req_ready;
			rsp_hs = rsp_valid && rsp_ready;
			if (req_hs) begin
				range_request_effect(req, rsp_expected, rsp_want);
				if (rsp_expected)
					rsp_due.push_back(rsp_want);
			end
			if (rsp_hs) begin
				rsp_got = rsp;
				if (rsp_due.size() == 0) begin
					flag_mismatch("response word with none outstanding");
				end else begin
					rsp_want = rsp_due.pop_front();
					if (rsp_got.range_total !== rsp_want.range_total)
						flag_mismatch($sformatf("range_total got %0d want %0d",
							rsp_got.range_total, rsp_want.range_total));
					if (rsp_got.bad_range !== rsp_want.bad_range)
						flag_mismatch($sformatf("bad_range got %b want %b",
							rsp_got.bad_range, rsp_want.bad_range));
				end
			end
			// watchdog: any handshake restarts the count
			if (req_hs || rsp_hs)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		// Directed words on a tiny array: empty-array rejects, extreme values,
		// wrap on add, both copy directions, off-by-one bounds.
		queue_req(FUNC_SUM, 1, 1, 0, 32'h0);
		queue_req(FUNC_ADD, 1, 1, 0, 32'h5);
		queue_req(FUNC_COPY, 1, 1, 0, 32'h0);
		queue_req(FUNC_LOAD, 2047, 0, 1023, 32'h7FFF_FFFF);
		queue_req(FUNC_LOAD, 0, 2047, 0, 32'h8000_0000);
		queue_req(FUNC_LOAD, 2047, 2047, 1023, 32'h0000_0000);
		queue_req(FUNC_LOAD, 0, 0, 0, 32'hFFFF_FFFF);
		queue_req(FUNC_LOAD, 1, 1, 0, 32'h0000_0001);
		queue_req(FUNC_SUM, 1, 5, 0, 32'h0);
		queue_req(FUNC_SUM, 1, 1, 1023, 32'hFFFF_FFFF);
		queue_req(FUNC_SUM, 5, 5, 0, 32'h0);
		queue_req(FUNC_ADD, 1, 5, 0, 32'h7FFF_FFFF);
		queue_req(FUNC_SUM, 1, 5, 0, 32'h0);
		queue_req(FUNC_ADD, 3, 2, 0, 32'h1);
		queue_req(FUNC_SUM, 0, 3, 0, 32'h0);
		queue_req(FUNC_SUM, 2, 6, 0, 32'h0);
		queue_req(FUNC_SUM, 2047, 2047, 0, 32'h0);
		queue_req(FUNC_COPY, 1, 2, 2, 32'h0);
		queue_req(FUNC_SUM, 1, 5, 0, 32'h0);
		queue_req(FUNC_COPY, 3, 1, 2, 32'h0);
		queue_req(FUNC_SUM, 1, 5, 0, 32'h0);
		queue_req(FUNC_COPY, 1, 1, 5, 32'h0);
		queue_req(FUNC_COPY, 1, 2, 1023, 32'h0);
		queue_req(FUNC_COPY, 0, 1, 0, 32'h0);
		queue_req(FUNC_SUM, 1024, 1024, 0, 32'h0);

		repeat (180)
			queue_random_req();

		// Swap the idle odds; the first word here starts the long receiver
		// hold-off, and the sums behind it back the block up.
		gen_phase = 1;
		gen_drain = 1'b1;
		gen_hold = 1'b1;
		repeat (6)
			queue_req(FUNC_SUM, 1, fill_level, 0, 32'h0);
		repeat (175)
			queue_random_req();

		// No idling: pause for all responses, then run walks over the whole
		// loaded length and random words.
		gen_phase = 2;
		gen_drain = 1'b1;
		queue_req(FUNC_SUM, 1, fill_level, 0, 32'h0);
		queue_req(FUNC_ADD, 1, fill_level, 0, 32'h8000_0000);
		queue_req(FUNC_COPY, 1, 1, fill_level - 1, 32'h0);
		queue_req(FUNC_COPY, 1, 2, fill_level - 2, 32'h0);
		queue_req(FUNC_COPY, 2, 1, fill_level - 2, 32'h0);
		queue_req(FUNC_SUM, 1, fill_level, 0, 32'h0);
		queue_req(FUNC_SUM, fill_level, fill_level, 0, 32'h0);
		repeat (185)
			queue_random_req();

		// Hold reset, then release it between edges.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || req_valid)
			@(negedge clk);
		while (rsp_due.size() != 0)
			@(negedge clk);
		// let any walk still in progress finish and flush out stray responses
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (rsp_due.size() != 0)
			flag_mismatch($sformatf("%0d responses never arrived", rsp_due.size()));
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
